FILE: design/mbcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcs_pkg: shared types and constants of the bay charge supervisor
// Bay record, state and command codes, register indexes and limit constants.
// ----------------------------------------------------------------------------
package mbcs_pkg;

    localparam int BAYS = 6;
    localparam int BAY_W = 3;
    localparam logic [7:0] RETRY_LIMIT = 8'd3;
    localparam logic [31:0] DISCHARGE_TIMEOUT_MS = 32'd14400000;
    localparam logic [9:0] FULL_LEVEL = 10'd990;

    typedef enum logic [2:0] {
        ST_INIT = 3'd0, ST_ABSENT = 3'd1, ST_CHECK = 3'd2, ST_CHARGE = 3'd3,
        ST_DISCH = 3'd4, ST_STABLE = 3'd5, ST_FAULT = 3'd6, ST_UNUSED = 3'd7
    } bay_fsm_t;

    typedef enum logic [1:0] {
        CMD_STABLE = 2'd0, CMD_CHARGE = 2'd1, CMD_DISCH = 2'd2, CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0, ERR_LINK = 2'd1, ERR_TEMP = 2'd2, ERR_TIMEOUT = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        RD_MUX_FAIL = 2'd0, RD_GAUGE_FAIL = 2'd1, RD_OK = 2'd2, RD_UNUSED = 2'd3
    } rd_t;

    // Tick sequencer of the top level
    typedef enum logic [1:0] {
        S_IDLE = 2'd0, S_PICK = 2'd1, S_STEP = 2'd2
    } seq_t;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_SLOTS = 3'd1;
    localparam logic [2:0] REG_LOW = 3'd2;
    localparam logic [2:0] REG_DIS = 3'd3;
    localparam logic [2:0] REG_SETTLE = 3'd4;
    localparam logic [2:0] REG_TLIM = 3'd5;
    localparam logic [2:0] REG_TREC = 3'd6;
    localparam logic [2:0] REG_TOUT = 3'd7;

    typedef struct packed {
        bay_fsm_t           st;
        cmd_t               cmd;
        err_t               err;
        logic               present;
        logic               link;
        logic [7:0]         fails;
        logic [9:0]         soc;
        logic signed [11:0] temp;
        logic [31:0]        start;
    } bay_rec_t;

    typedef struct packed {
        logic               mode;
        logic [2:0]         slots;
        logic [9:0]         low;
        logic [9:0]         dis;
        logic [9:0]         settle;
        logic signed [11:0] tlim;
        logic signed [11:0] trec;
        logic [31:0]        tout;
    } cfg_t;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic             scan;       // scan write in progress
        logic [BAY_W-1:0] scan_bay;
        logic             present;
        rd_t              rd;
        logic [9:0]       soc;
        logic signed [11:0] temp;
        logic             shift;      // rotate records one cell
        logic             pick;       // compare pass for a discharge slot
        logic             step;       // step head cell's bay
        logic             step_pres;
        logic             step_allow;
        logic [31:0]      now;
    } cell_ctl_t;

endpackage

FILE: design/mbcs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcs_cell: one bay record in the rotating row
// Holds a bay record and its discharge grant; applies scans, steps the bay
// state machine when at the head, and takes over the next cell's record on a shift.
// ----------------------------------------------------------------------------
module mbcs_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mbcs_pkg::BAY_W-1:0]    idx,
    input  mbcs_pkg::cfg_t                cfg,
    input  mbcs_pkg::cell_ctl_t           ctl,
    input  logic                          is_head,
    input  logic                          grant_set,
    input  logic                          grant_clr,
    input  mbcs_pkg::bay_rec_t            rec_in,
    input  logic                          allow_in,
    input  logic [mbcs_pkg::BAY_W-1:0]    id_in,
    output mbcs_pkg::bay_rec_t            rec_out,
    output mbcs_pkg::bay_rec_t            step_out,
    output logic                          allow_out,
    output logic [mbcs_pkg::BAY_W-1:0]    id_out,
    output logic                          elig
);

    mbcs_pkg::bay_rec_t rec_reg, rec_next, stepped;
    logic allow_reg, allow_next;
    logic [mbcs_pkg::BAY_W-1:0] id_reg;
    logic hot;
    logic [31:0] elapsed;

    assign rec_out   = rec_reg;
    assign step_out  = stepped;
    assign allow_out = allow_reg;
    assign id_out    = id_reg;
    assign hot       = rec_reg.temp >= cfg.tlim;
    assign elapsed   = ctl.now - rec_reg.start;

    // eligible to be picked for discharge in this pass
    assign elig = !allow_reg && rec_reg.present && rec_reg.link &&
                  rec_reg.st != mbcs_pkg::ST_FAULT && !hot;

    // bay state machine step
    always_comb begin
        stepped = rec_reg;
        stepped.present = ctl.step_pres;
        unique case (rec_reg.st)
            mbcs_pkg::ST_ABSENT: begin
                stepped.cmd = mbcs_pkg::CMD_STABLE;
                stepped.link = 1'b0;
                stepped.err = mbcs_pkg::ERR_NONE;
                if (ctl.step_pres) stepped.st = mbcs_pkg::ST_CHECK;
            end
            mbcs_pkg::ST_CHECK, mbcs_pkg::ST_STABLE: begin
                stepped.cmd = mbcs_pkg::CMD_STABLE;
                if (!ctl.step_pres) begin
                    stepped.st = mbcs_pkg::ST_ABSENT;
                end else if (!rec_reg.link) begin
                    if (rec_reg.fails >= mbcs_pkg::RETRY_LIMIT) begin
                        stepped.st = mbcs_pkg::ST_FAULT;
                        stepped.err = mbcs_pkg::ERR_LINK;
                    end
                end else if (hot) begin
                    stepped.st = mbcs_pkg::ST_FAULT;
                    stepped.err = mbcs_pkg::ERR_TEMP;
                end else if (rec_reg.st == mbcs_pkg::ST_STABLE) begin
                    if (rec_reg.soc < cfg.low || rec_reg.soc > cfg.dis)
                        stepped.st = mbcs_pkg::ST_CHECK;
                end else if ((cfg.mode == 1'b0 && rec_reg.soc < cfg.low) ||
                             (cfg.mode == 1'b1 && rec_reg.soc < mbcs_pkg::FULL_LEVEL)) begin
                    stepped.cmd = mbcs_pkg::CMD_CHARGE;
                    stepped.start = ctl.now;
                    stepped.st = mbcs_pkg::ST_CHARGE;
                end else if (cfg.mode == 1'b0 && rec_reg.soc > cfg.dis && allow_reg) begin
                    stepped.cmd = mbcs_pkg::CMD_DISCH;
                    stepped.start = ctl.now;
                    stepped.st = mbcs_pkg::ST_DISCH;
                end else begin
                    stepped.st = mbcs_pkg::ST_STABLE;
                end
            end
            mbcs_pkg::ST_CHARGE, mbcs_pkg::ST_DISCH: begin
                if (!ctl.step_pres) begin
                    stepped.cmd = mbcs_pkg::CMD_STABLE;
                    stepped.st = mbcs_pkg::ST_ABSENT;
                end else if (!rec_reg.link) begin
                    stepped.cmd = mbcs_pkg::CMD_STABLE;
                    if (rec_reg.fails >= mbcs_pkg::RETRY_LIMIT) begin
                        stepped.st = mbcs_pkg::ST_FAULT;
                        stepped.err = mbcs_pkg::ERR_LINK;
                    end
                end else if (hot) begin
                    stepped.cmd = mbcs_pkg::CMD_STABLE;
                    stepped.st = mbcs_pkg::ST_FAULT;
                    stepped.err = mbcs_pkg::ERR_TEMP;
                end else if (elapsed > ((rec_reg.st == mbcs_pkg::ST_CHARGE) ?
                             cfg.tout : mbcs_pkg::DISCHARGE_TIMEOUT_MS)) begin
                    stepped.cmd = mbcs_pkg::CMD_STABLE;
                    stepped.st = mbcs_pkg::ST_FAULT;
                    stepped.err = mbcs_pkg::ERR_TIMEOUT;
                end else if (rec_reg.st == mbcs_pkg::ST_CHARGE) begin
                    if (rec_reg.soc >= cfg.settle) begin
                        stepped.cmd = mbcs_pkg::CMD_STABLE;
                        stepped.st = mbcs_pkg::ST_STABLE;
                    end else begin
                        stepped.cmd = mbcs_pkg::CMD_CHARGE;
                    end
                end else if (!allow_reg) begin
                    stepped.cmd = mbcs_pkg::CMD_STABLE;
                    stepped.st = mbcs_pkg::ST_CHECK;
                end else if (rec_reg.soc <= cfg.settle) begin
                    stepped.cmd = mbcs_pkg::CMD_STABLE;
                    stepped.st = mbcs_pkg::ST_STABLE;
                end else begin
                    stepped.cmd = mbcs_pkg::CMD_DISCH;
                end
            end
            mbcs_pkg::ST_FAULT: begin
                stepped.cmd = mbcs_pkg::CMD_STABLE;
                if (!ctl.step_pres) begin
                    stepped.st = mbcs_pkg::ST_ABSENT;
                end else if (rec_reg.link &&
                             ((rec_reg.err == mbcs_pkg::ERR_TEMP &&
                               rec_reg.temp <= cfg.trec) ||
                              rec_reg.err == mbcs_pkg::ERR_LINK)) begin
                    stepped.err = mbcs_pkg::ERR_NONE;
                    stepped.st = mbcs_pkg::ST_CHECK;
                end
            end
            default: begin
                stepped.cmd = mbcs_pkg::CMD_STABLE;
                stepped.err = mbcs_pkg::ERR_NONE;
                stepped.st = ctl.step_pres ? mbcs_pkg::ST_CHECK : mbcs_pkg::ST_ABSENT;
            end
        endcase
    end

    // next record and grant: shift, step, grant set or clear, or scan write
    always_comb begin
        rec_next = rec_reg;
        allow_next = allow_reg;
        if (ctl.step && is_head) rec_next = stepped;
        if (ctl.shift) begin
            rec_next = rec_in;
            allow_next = allow_in;
        end
        if (grant_set) allow_next = 1'b1;
        if (grant_clr) allow_next = 1'b0;
        if (ctl.scan && ctl.scan_bay == id_reg) begin
            rec_next.present = ctl.present;
            if (!ctl.present) begin
                rec_next.link = 1'b0;
                rec_next.fails = 8'd0;
            end else if (ctl.rd == mbcs_pkg::RD_OK) begin
                rec_next.soc = ctl.soc;
                rec_next.temp = ctl.temp;
                rec_next.link = 1'b1;
                rec_next.fails = 8'd0;
            end else begin
                rec_next.link = 1'b0;
                if (ctl.rd != mbcs_pkg::RD_MUX_FAIL && rec_reg.fails != 8'hFF)
                    rec_next.fails = rec_reg.fails + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg <= '{st: mbcs_pkg::ST_INIT, cmd: mbcs_pkg::CMD_STABLE,
                         err: mbcs_pkg::ERR_NONE, default: '0};
            allow_reg <= 1'b0;
            id_reg <= idx;
        end else begin
            rec_reg <= rec_next;
            allow_reg <= allow_next;
            if (ctl.shift) id_reg <= id_in;
        end
    end

endmodule

FILE: design/multi_bay_charge_supervisor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_bay_charge_supervisor_top: six-bay battery charge supervisor
//
//   channel  | dir | beat contents
//   s_axis   | in  | tdata: action, bay_index, bay_present, read_result,
//            |     |        soc_reading, temp_reading, present_mask, now_ms
//   m_axis   | out | tdata: bay, command, bay_state, error; tlast: last
//   cfg      | in  | cfg_index (register), cfg_data
//
// A tick runs up to 6 compare passes (one per discharge slot) over the row of
// cells, then rotates the row one cell per cycle while the output is not stalled
// and steps the bay at the head.
// Reset is synchronous; records return to init. Output is one register deep.
// ----------------------------------------------------------------------------
module multi_bay_charge_supervisor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] action [3:1] bay_index [4] bay_present [6:5] read_result
    // [16:7] soc_reading [28:17] temp_reading [34:29] present_mask
    // [66:35] now_ms [71:67] zero
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] bay [4:3] command [7:5] bay_state [9:8] error [15:10] zero
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int N = mbcs_pkg::BAYS;

    mbcs_pkg::seq_t                seq_reg, seq_next;
    mbcs_pkg::cfg_t                cfg_reg;
    mbcs_pkg::cell_ctl_t           ctl;
    logic [2:0]                    cnt_reg, cnt_next;
    logic [2:0]                    slots_c;
    logic [5:0]                    mask_reg;
    logic [31:0]                   now_reg;
    logic                          ov_reg;
    logic [15:0]                   od_reg;
    logic                          ol_reg;
    logic                          s_acc;

    mbcs_pkg::bay_rec_t            rec_o [N];
    mbcs_pkg::bay_rec_t            step_o [N];
    logic                          allow_o [N];
    logic [mbcs_pkg::BAY_W-1:0]    id_o [N];
    logic                          elig [N];
    logic                          gset [N];
    logic                          gclr;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = (seq_reg == mbcs_pkg::S_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = od_reg;
    assign m_axis_tlast = ol_reg;
    assign slots_c = (cfg_reg.slots == 3'd0) ? 3'd1 :
                     (cfg_reg.slots > 3'(N)) ? 3'(N) : cfg_reg.slots;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{mode: 1'b0, slots: 3'd1, low: 10'd280, dis: 10'd320,
                         settle: 10'd300, tlim: 12'sd450, trec: 12'sd400,
                         tout: 32'd14400000};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mbcs_pkg::REG_MODE:   cfg_reg.mode <= cfg_data[0];
                mbcs_pkg::REG_SLOTS:  cfg_reg.slots <= cfg_data[2:0];
                mbcs_pkg::REG_LOW:    cfg_reg.low <= cfg_data[9:0];
                mbcs_pkg::REG_DIS:    cfg_reg.dis <= cfg_data[9:0];
                mbcs_pkg::REG_SETTLE: cfg_reg.settle <= cfg_data[9:0];
                mbcs_pkg::REG_TLIM:   cfg_reg.tlim <= cfg_data[11:0];
                mbcs_pkg::REG_TREC:   cfg_reg.trec <= cfg_data[11:0];
                default:              cfg_reg.tout <= cfg_data;
            endcase
        end
    end

    // pick the eligible bay with highest charge above threshold (lowest id on tie)
    always_comb begin
        logic [9:0] best_lvl;
        logic       found;
        logic [2:0] best_i;
        best_lvl = cfg_reg.dis;
        found = 1'b0;
        best_i = '0;
        for (int k = 0; k < N; k++) begin
            if (elig[k] && (rec_o[k].soc > best_lvl ||
                (found && rec_o[k].soc == best_lvl && id_o[k] < id_o[best_i]))) begin
                best_lvl = rec_o[k].soc;
                best_i = 3'(k);
                found = 1'b1;
            end
        end
        for (int k = 0; k < N; k++)
            gset[k] = (seq_reg == mbcs_pkg::S_PICK) && found && (best_i == 3'(k));
    end

    // sequencer
    always_comb begin
        seq_next = seq_reg;
        cnt_next = cnt_reg;
        ctl = '0;
        ctl.now = now_reg;
        ctl.step_pres = mask_reg[id_o[0]];
        ctl.step_allow = allow_o[0];
        gclr = 1'b0;
        unique case (seq_reg)
            mbcs_pkg::S_IDLE: begin
                if (s_acc && !s_axis_tdata[0]) begin
                    ctl.scan = 1'b1;
                    ctl.scan_bay = s_axis_tdata[3:1];
                    ctl.present = s_axis_tdata[4];
                    ctl.rd = mbcs_pkg::rd_t'(s_axis_tdata[6:5]);
                    ctl.soc = s_axis_tdata[16:7];
                    ctl.temp = s_axis_tdata[28:17];
                end else if (s_acc) begin
                    seq_next = mbcs_pkg::S_PICK;
                    cnt_next = '0;
                end
            end
            mbcs_pkg::S_PICK: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg + 3'd1 == slots_c) begin
                    seq_next = mbcs_pkg::S_STEP;
                    cnt_next = '0;
                end
            end
            mbcs_pkg::S_STEP: begin
                if (!ov_reg || m_axis_tready) begin
                    ctl.step = 1'b1;
                    ctl.shift = 1'b1;
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'(N - 1)) begin
                        seq_next = mbcs_pkg::S_IDLE;
                        gclr = 1'b1;
                    end
                end
            end
            default: seq_next = mbcs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg <= mbcs_pkg::S_IDLE;
            cnt_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            seq_reg <= seq_next;
            cnt_reg <= cnt_next;
            if (ctl.step) ov_reg <= 1'b1;
            else if (m_axis_tready) ov_reg <= 1'b0;
        end
    end

    // tick payload and result register; the result is the stepped head bay
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            mask_reg <= s_axis_tdata[34:29];
            now_reg <= s_axis_tdata[66:35];
        end
        if (ctl.step) begin
            od_reg <= {6'd0, step_o[0].err, step_o[0].st, step_o[0].cmd, id_o[0]};
            ol_reg <= (cnt_reg == 3'(N - 1));
        end
    end

    // row of cells: head is cell 0; stepped head record enters the tail
    generate
        for (genvar g = 0; g < N; g++) begin : g_cell
            localparam int NX = (g == N - 1) ? 0 : g + 1;
            mbcs_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .idx       (3'(g)),
                .cfg       (cfg_reg),
                .ctl       (ctl),
                .is_head   (g == 0),
                .grant_set (gset[g]),
                .grant_clr (gclr),
                .rec_in    ((g == N - 1) ? step_o[0] : rec_o[NX]),
                .allow_in  (allow_o[NX]),
                .id_in     (id_o[NX]),
                .rec_out   (rec_o[g]),
                .step_out  (step_o[g]),
                .allow_out (allow_o[g]),
                .id_out    (id_o[g]),
                .elig      (elig[g])
            );
        end
    endgenerate

endmodule
